FILE: rtl/core/lzcc_pkg.sv
// ----------------------------------------------------------------------------
// lzcc_pkg: shared types and constants of the context chain decoder
// Sizes, command codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package lzcc_pkg;

	localparam int WINDOW_BYTES_DEF = 16384;
	localparam int HEAD_ENTRIES_DEF = 4096;
	localparam logic [7:0] TOKEN_BASE = 8'hF0;
	localparam int BYTE_W = 8;
	localparam int DATA_W = 32;
	localparam int COUNT_W = 3;
	localparam int STEPS_W = 4;
	localparam int BUF_DEPTH = 256;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [BYTE_W-1:0]   value;
		logic [STEPS_W-1:0]  steps;
	} cmd_t;

endpackage

FILE: rtl/core/lzcc_in_if.sv
// ----------------------------------------------------------------------------
// lzcc_in_if: compressed byte channel
// Valid/ready channel that carries one compressed byte per transfer.
// ----------------------------------------------------------------------------
interface lzcc_in_if;
	logic                          valid;
	logic                          ready;
	logic [lzcc_pkg::BYTE_W-1:0]   in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

FILE: rtl/core/lzcc_out_if.sv
// ----------------------------------------------------------------------------
// lzcc_out_if: decoded result channel
// Valid/ready channel that carries up to four decoded bytes per transfer.
// ----------------------------------------------------------------------------
interface lzcc_out_if;
	logic                           valid;
	logic                           ready;
	logic [lzcc_pkg::DATA_W-1:0]    out_data;
	logic [lzcc_pkg::COUNT_W-1:0]   out_count;
	logic                           end_of_string;
	logic                           last;

	modport source (output valid, output out_data, output out_count,
		output end_of_string, output last, input ready);
	modport sink (input valid, input out_data, input out_count,
		input end_of_string, input last, output ready);
endinterface

FILE: rtl/core/lz_context_chain_decoder_unit.sv
// ----------------------------------------------------------------------------
// lz_context_chain_decoder_unit: LZ hash chain decoder with rolling context
// Front classifier, command queue and execution engine over window tables.
//
// Channel   Direction  Transfer payload
// in_ch     in         in_byte: one compressed byte
// out_ch    out        out_data, out_count, end_of_string, last
//
// A literal byte is pushed directly; a copy walks the chain, reads its bytes
// from the window into the copy buffer and then pushes them, all bounded by
// the single read port of each table.
// After reset a clearing pass over max(WINDOW_BYTES, HEAD_ENTRIES) entries runs
// before the first byte is taken. A stalled output holds the engine, while
// the queue lets the front keep taking bytes until the queue is full.
// ----------------------------------------------------------------------------
module lz_context_chain_decoder_unit #(
	parameter int WINDOW_BYTES = lzcc_pkg::WINDOW_BYTES_DEF,
	parameter int HEAD_ENTRIES = lzcc_pkg::HEAD_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lzcc_in_if.sink    in_ch,
	lzcc_out_if.source out_ch
);

	logic           cleared;
	logic           f_valid;
	logic           f_ready;
	lzcc_pkg::cmd_t f_cmd;
	logic           q_valid;
	logic           q_ready;
	lzcc_pkg::cmd_t q_cmd;

	lzcc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cleared(cleared),
		.in_ch(in_ch),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd(f_cmd)
	);

	lzcc_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_cmd(f_cmd),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_cmd(q_cmd)
	);

	lzcc_back #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.HEAD_ENTRIES(HEAD_ENTRIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cleared(cleared),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd(q_cmd),
		.out_ch(out_ch)
	);

endmodule

FILE: rtl/core/lzcc_ram.sv
// ----------------------------------------------------------------------------
// lzcc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read sees the old data.
// ----------------------------------------------------------------------------
module lzcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/lzcc_front.sv
// ----------------------------------------------------------------------------
// lzcc_front: token classifier
// Accepts compressed bytes and turns them into literal, copy and end commands.
// ----------------------------------------------------------------------------
module lzcc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cleared,
	lzcc_in_if.sink        in_ch,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output lzcc_pkg::cmd_t cmd
);

	logic                           pending_q;
	logic [lzcc_pkg::STEPS_W-1:0]   steps_q;
	logic                           take;
	logic [lzcc_pkg::BYTE_W-1:0]    b;

	assign b = in_ch.in_byte;
	assign in_ch.ready = cleared && cmd_ready;
	assign take = in_ch.valid && in_ch.ready;

	always_comb begin
		cmd.steps = steps_q;
		cmd.value = b;
		cmd.kind = lzcc_pkg::CMD_LIT;
		cmd_valid = 1'b0;
		if (pending_q) begin
			cmd_valid = in_ch.valid && cleared;
			if (b == '0) begin
				cmd.value = lzcc_pkg::TOKEN_BASE | {4'h0, steps_q};
			end else begin
				cmd.kind = lzcc_pkg::CMD_COPY;
			end
		end else if (b < lzcc_pkg::TOKEN_BASE) begin
			cmd_valid = in_ch.valid && cleared;
			if (b == '0) begin
				cmd.kind = lzcc_pkg::CMD_END;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			steps_q <= '0;
		end else if (take) begin
			if (pending_q) begin
				pending_q <= 1'b0;
			end else if (b >= lzcc_pkg::TOKEN_BASE) begin
				pending_q <= 1'b1;
				steps_q <= b[lzcc_pkg::STEPS_W-1:0];
			end
		end
	end

endmodule

FILE: rtl/core/lzcc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lzcc_cmd_fifo: two-entry command queue
// Decouples the classifier from the execution engine.
// ----------------------------------------------------------------------------
module lzcc_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  lzcc_pkg::cmd_t wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output lzcc_pkg::cmd_t rd_cmd
);

	lzcc_pkg::cmd_t slot_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     fill_q;
	logic           push;
	logic           pop;

	assign wr_ready = fill_q != 2'd2;
	assign rd_valid = fill_q != 2'd0;
	assign rd_cmd = slot_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/core/lzcc_back.sv
// ----------------------------------------------------------------------------
// lzcc_back: execution engine
// Clears the tables, walks the chain, copies and pushes bytes, packs results.
// ----------------------------------------------------------------------------
module lzcc_back #(
	parameter int WINDOW_BYTES = lzcc_pkg::WINDOW_BYTES_DEF,
	parameter int HEAD_ENTRIES = lzcc_pkg::HEAD_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	output logic           cleared,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  lzcc_pkg::cmd_t cmd,
	lzcc_out_if.source     out_ch
);

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int HW = $clog2(HEAD_ENTRIES);
	localparam int CLR_DEPTH = (WINDOW_BYTES > HEAD_ENTRIES) ? WINDOW_BYTES : HEAD_ENTRIES;
	localparam int CW = $clog2(CLR_DEPTH);
	localparam logic [CW-1:0] CLR_LAST = CW'(CLR_DEPTH - 1);
	localparam int BW = lzcc_pkg::BYTE_W;
	localparam int BAW = $clog2(lzcc_pkg::BUF_DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD_RD,
		ST_WALK,
		ST_READ,
		ST_DRAIN,
		ST_PUSH_A,
		ST_PUSH_B,
		ST_EMIT
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 clr_q;
	logic                          is_lit_q;
	logic [BW-1:0]                 lit_q;
	logic [lzcc_pkg::STEPS_W-1:0]  steps_q;
	logic [BW-1:0]                 len_q;
	logic [BW-1:0]                 k_q;
	logic [AW-1:0]                 j_q;
	logic                          from_head_q;
	logic                          pend_q;
	logic [BAW-1:0]                pend_idx_q;
	logic [AW-1:0]                 pos_q;
	logic [HW-1:0]                 ctx_q;
	logic [lzcc_pkg::DATA_W-1:0]   word_q;
	logic [lzcc_pkg::COUNT_W-1:0]  wcnt_q;
	logic                          ov_q;
	logic [lzcc_pkg::DATA_W-1:0]   od_q;
	logic [lzcc_pkg::COUNT_W-1:0]  oc_q;
	logic                          oe_q;
	logic                          ol_q;

	logic [AW-1:0]                 head_rdata;
	logic [AW-1:0]                 chain_rdata;
	logic [BW-1:0]                 win_rdata;
	logic [BW-1:0]                 buf_rdata;
	logic                          clr_on;
	logic                          push_on;
	logic [AW-1:0]                 walk_cur;
	logic [BW-1:0]                 pb;
	logic [lzcc_pkg::DATA_W-1:0]   new_word;
	logic [HW+3:0]                 ctx_wide;
	logic                          last_byte;
	logic                          out_free;
	logic                          emit;

	assign clr_on = state_q == ST_CLEAR;
	assign push_on = state_q == ST_PUSH_B;
	assign cleared = !clr_on;
	assign walk_cur = from_head_q ? head_rdata : chain_rdata;
	assign pb = is_lit_q ? lit_q : buf_rdata;
	assign new_word = word_q | ({{(lzcc_pkg::DATA_W-BW){1'b0}}, pb} << {wcnt_q[1:0], 3'b000});
	assign ctx_wide = {ctx_q, 4'h0} ^ {{(HW-4){1'b0}}, pb};
	assign last_byte = k_q == len_q - 8'd1;
	assign out_free = !ov_q || out_ch.ready;
	assign cmd_ready = state_q == ST_IDLE && (cmd.kind != lzcc_pkg::CMD_END || out_free);
	assign emit = (state_q == ST_IDLE && cmd_valid && cmd_ready
			&& cmd.kind == lzcc_pkg::CMD_END)
		|| (state_q == ST_PUSH_B && (wcnt_q == 3'd3 || last_byte) && out_free)
		|| (state_q == ST_EMIT && out_free);

	assign out_ch.valid = ov_q;
	assign out_ch.out_data = od_q;
	assign out_ch.out_count = oc_q;
	assign out_ch.end_of_string = oe_q;
	assign out_ch.last = ol_q;

	lzcc_ram #(.WIDTH(BW), .DEPTH(WINDOW_BYTES)) u_window (
		.clk(clk),
		.we(clr_on || push_on),
		.waddr(clr_on ? clr_q[AW-1:0] : pos_q),
		.wdata(clr_on ? '0 : pb),
		.raddr(j_q + AW'(k_q)),
		.rdata(win_rdata)
	);

	lzcc_ram #(.WIDTH(AW), .DEPTH(WINDOW_BYTES)) u_chain (
		.clk(clk),
		.we(clr_on || push_on),
		.waddr(clr_on ? clr_q[AW-1:0] : pos_q),
		.wdata(clr_on ? '0 : head_rdata),
		.raddr(walk_cur),
		.rdata(chain_rdata)
	);

	lzcc_ram #(.WIDTH(AW), .DEPTH(HEAD_ENTRIES)) u_head (
		.clk(clk),
		.we(clr_on || push_on),
		.waddr(clr_on ? clr_q[HW-1:0] : ctx_q),
		.wdata(clr_on ? '0 : pos_q),
		.raddr(ctx_q),
		.rdata(head_rdata)
	);

	lzcc_ram #(.WIDTH(BW), .DEPTH(lzcc_pkg::BUF_DEPTH)) u_copy_buf (
		.clk(clk),
		.we(pend_q),
		.waddr(pend_idx_q),
		.wdata(win_rdata),
		.raddr(k_q),
		.rdata(buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			is_lit_q <= 1'b0;
			lit_q <= '0;
			steps_q <= '0;
			len_q <= '0;
			k_q <= '0;
			j_q <= '0;
			from_head_q <= 1'b0;
			pend_q <= 1'b0;
			pend_idx_q <= '0;
			pos_q <= '0;
			ctx_q <= '0;
			word_q <= '0;
			wcnt_q <= '0;
			ov_q <= 1'b0;
			od_q <= '0;
			oc_q <= '0;
			oe_q <= 1'b0;
			ol_q <= 1'b0;
		end else begin
			ov_q <= emit || (ov_q && !out_ch.ready);
			pend_q <= state_q == ST_READ;
			pend_idx_q <= k_q;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						k_q <= '0;
						lit_q <= cmd.value;
						len_q <= (cmd.kind == lzcc_pkg::CMD_LIT) ? 8'd1 : cmd.value;
						steps_q <= cmd.steps;
						case (cmd.kind)
							lzcc_pkg::CMD_LIT: begin
								is_lit_q <= 1'b1;
								state_q <= ST_PUSH_A;
							end
							lzcc_pkg::CMD_COPY: begin
								is_lit_q <= 1'b0;
								state_q <= ST_HEAD_RD;
							end
							default: begin
								ctx_q <= '0;
								od_q <= '0;
								oc_q <= '0;
								oe_q <= 1'b1;
								ol_q <= 1'b1;
							end
						endcase
					end
				end
				ST_HEAD_RD: begin
					from_head_q <= 1'b1;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					from_head_q <= 1'b0;
					j_q <= walk_cur;
					if (steps_q == '0) begin
						state_q <= ST_READ;
					end else begin
						steps_q <= steps_q - 4'd1;
					end
				end
				ST_READ: begin
					if (last_byte) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 8'd1;
					end
				end
				ST_DRAIN: begin
					k_q <= '0;
					state_q <= ST_PUSH_A;
				end
				ST_PUSH_A: begin
					state_q <= ST_PUSH_B;
				end
				ST_PUSH_B: begin
					pos_q <= pos_q + AW'(1);
					ctx_q <= ctx_wide[HW-1:0];
					if (wcnt_q == 3'd3 || last_byte) begin
						if (out_free) begin
							od_q <= new_word;
							oc_q <= wcnt_q + 3'd1;
							oe_q <= 1'b0;
							ol_q <= last_byte;
							word_q <= '0;
							wcnt_q <= '0;
							k_q <= k_q + 8'd1;
							state_q <= last_byte ? ST_IDLE : ST_PUSH_A;
						end else begin
							word_q <= new_word;
							wcnt_q <= wcnt_q + 3'd1;
							state_q <= ST_EMIT;
						end
					end else begin
						word_q <= new_word;
						wcnt_q <= wcnt_q + 3'd1;
						k_q <= k_q + 8'd1;
						state_q <= ST_PUSH_A;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						od_q <= word_q;
						oc_q <= wcnt_q;
						oe_q <= 1'b0;
						ol_q <= last_byte;
						word_q <= '0;
						wcnt_q <= '0;
						k_q <= k_q + 8'd1;
						state_q <= last_byte ? ST_IDLE : ST_PUSH_A;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/sv/lz_context_chain_decoder_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_context_chain_decoder_unit_checker: result predictor and comparator
// Watches both channels, models the window, chain and head tables to work out
// the decoded results of each accepted byte, and compares them in order.
// ----------------------------------------------------------------------------
module lz_context_chain_decoder_unit_checker (
	input  logic       clk,
	input  logic       arst_n,
	lzcc_in_if.sink    in_mon,
	lzcc_out_if.sink   out_mon,
	output int         fail_count,
	output int         pending_results
);

	localparam int WIN = lzcc_pkg::WINDOW_BYTES_DEF;
	localparam int HEADS = lzcc_pkg::HEAD_ENTRIES_DEF;

	typedef struct packed {
		logic [lzcc_pkg::DATA_W-1:0]  data;
		logic [lzcc_pkg::COUNT_W-1:0] count;
		logic                         eos;
		logic                         last;
	} decoded_t;

	logic [7:0]  window_mem [WIN];
	logic [13:0] chain_mem [WIN];
	logic [13:0] head_mem [HEADS];
	logic [13:0] wr_pos;
	logic [11:0] context_reg;
	logic        token_held;
	logic [3:0]  held_steps;
	decoded_t    expected_q [$];

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	task automatic push_decoded(input logic [7:0] b);
		chain_mem[wr_pos] = head_mem[context_reg];
		head_mem[context_reg] = wr_pos;
		window_mem[wr_pos] = b;
		wr_pos = wr_pos + 14'd1;
		context_reg = {context_reg[7:0], 4'h0} ^ {4'h0, b};
	endtask

	task automatic queue_bytes(input logic [7:0] bytes [256], input int n);
		decoded_t r;
		for (int i = 0; i < n; i += 4) begin
			r = '0;
			r.count = (n - i > 4) ? 3'd4 : 3'(n - i);
			for (int b = 0; b < r.count; b++)
				r.data[8*b +: 8] = bytes[i + b];
			r.last = (i + 4 >= n);
			expected_q.push_back(r);
		end
	endtask

	task automatic predict_byte(input logic [7:0] c);
		logic [7:0]  bytes [256];
		logic [13:0] src;
		decoded_t    r;
		if (token_held) begin
			token_held = 0;
			if (c == 8'd0) begin
				bytes[0] = lzcc_pkg::TOKEN_BASE + {4'h0, held_steps};
				push_decoded(bytes[0]);
				queue_bytes(bytes, 1);
			end else begin
				src = head_mem[context_reg];
				for (int s = 0; s < held_steps; s++)
					src = chain_mem[src];
				for (int k = 0; k < c; k++)
					bytes[k] = window_mem[14'(src + k)];
				for (int k = 0; k < c; k++)
					push_decoded(bytes[k]);
				queue_bytes(bytes, c);
			end
		end else if (c >= lzcc_pkg::TOKEN_BASE) begin
			token_held = 1;
			held_steps = c[3:0];
		end else if (c == 8'd0) begin
			context_reg = '0;
			r = '0;
			r.eos = 1;
			r.last = 1;
			expected_q.push_back(r);
		end else begin
			bytes[0] = c;
			push_decoded(c);
			queue_bytes(bytes, 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t e;
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				window_mem[i] = '0;
				chain_mem[i] = '0;
			end
			for (int i = 0; i < HEADS; i++)
				head_mem[i] = '0;
			wr_pos = '0;
			context_reg = '0;
			token_held = 0;
			held_steps = '0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					e = expected_q.pop_front();
					if (out_mon.out_data !== e.data)
						report_mismatch($sformatf("out_data %h, expected %h",
							out_mon.out_data, e.data));
					if (out_mon.out_count !== e.count)
						report_mismatch($sformatf("out_count %0d, expected %0d",
							out_mon.out_count, e.count));
					if (out_mon.end_of_string !== e.eos)
						report_mismatch($sformatf("end_of_string %b, expected %b",
							out_mon.end_of_string, e.eos));
					if (out_mon.last !== e.last)
						report_mismatch($sformatf("last %b, expected %b",
							out_mon.last, e.last));
				end
			end
			if (in_mon.valid && in_mon.ready)
				predict_byte(in_mon.in_byte);
		end
		pending_results = expected_q.size();
	end
endmodule

FILE: tb/sv/lz_context_chain_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_context_chain_decoder_unit_tb: top of the decoder testbench
// Drives directed and random compressed streams with random gaps and output
// stalls, including one long stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module lz_context_chain_decoder_unit_tb;

	localparam int IDLE_LIMIT = 100000;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count;
	int   pending_results;
	int   quiet_cycles = 0;
	bit   calm = 0;
	bit   hold_off = 0;
	bit   stim_done = 0;
	byte unsigned stream_q [$];

	lzcc_in_if  in_ch ();
	lzcc_out_if out_ch ();

	lz_context_chain_decoder_unit uut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch));

	lz_context_chain_decoder_unit_checker checker_i (.clk(clk), .arst_n(arst_n),
		.in_mon(in_ch), .out_mon(out_ch), .fail_count(fail_count),
		.pending_results(pending_results));

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.in_byte = '0;
		out_ch.ready = 0;
	end

	task automatic add_random_sequence();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			stream_q.push_back(8'($urandom_range(1, 8'hEF)));
		end else if (kind < 80) begin
			stream_q.push_back(8'(lzcc_pkg::TOKEN_BASE + $urandom_range(0, 15)));
			stream_q.push_back(($urandom_range(0, 9) == 0) ?
				8'($urandom_range(1, 255)) : 8'($urandom_range(1, 24)));
		end else if (kind < 88) begin
			stream_q.push_back(8'(lzcc_pkg::TOKEN_BASE + $urandom_range(0, 15)));
			stream_q.push_back(8'h00);
		end else if (kind < 94) begin
			stream_q.push_back(8'h00);
		end else begin
			stream_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		byte unsigned directed [] = '{8'h01, 8'h41, 8'hEF, 8'hF0, 8'h00, 8'hFF, 8'h00,
			8'hF0, 8'h04, 8'hF1, 8'h03, 8'hF0, 8'hFF, 8'h55, 8'hAA, 8'h00,
			8'hF3, 8'h07, 8'h7F, 8'h80, 8'hFE, 8'h01};
		foreach (directed[i])
			stream_q.push_back(directed[i]);
		while (stream_q.size() < 270)
			add_random_sequence();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		while (stream_q.size() > 0) begin
			@(posedge clk);
			if (in_ch.valid && in_ch.ready)
				void'(stream_q.pop_front());
			if (stream_q.size() > 0 && ((in_ch.valid && !in_ch.ready) || calm
					|| $urandom_range(0, 99) >= 7)) begin
				in_ch.valid <= 1;
				in_ch.in_byte <= stream_q[0];
			end else begin
				in_ch.valid <= 0;
			end
		end
		in_ch.valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (arst_n);
		wait (in_ch.ready);
		repeat (300) @(posedge clk);
		calm = 1;
		repeat (2000) @(posedge clk);
		calm = 0;
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ch.ready <= 0;
		else
			out_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 7);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[lz_context_chain_decoder_unit] ERROR");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_results == 0);
		repeat (1000) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("[lz_context_chain_decoder_unit] OK");
		else
			$display("[lz_context_chain_decoder_unit] ERROR");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/core/lzcc_pkg.sv
rtl/core/lzcc_in_if.sv
rtl/core/lzcc_out_if.sv
rtl/core/lzcc_ram.sv
rtl/core/lzcc_front.sv
rtl/core/lzcc_cmd_fifo.sv
rtl/core/lzcc_back.sv
rtl/core/lz_context_chain_decoder_unit.sv
tb/sv/lz_context_chain_decoder_unit_checker.sv
tb/sv/lz_context_chain_decoder_unit_tb.sv
